// ----- src/xor_metric_bucket_table_core_macros.svh -----
// assertion macros for the bucket table core
// no dependencies
`ifndef XOR_METRIC_BUCKET_TABLE_CORE_MACROS_SVH
`define XOR_METRIC_BUCKET_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define XMB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define XMB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XMB_ASSERT(lbl, clk, rstn, prop, msg)
`define XMB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- src/xmb_pkg.sv -----
// shared types and codes for the bucket table core
// no dependencies
package xmb_pkg;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_EVICTED = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;
  localparam logic [2:0] ST_ENTRY = 3'd5;
  localparam logic [2:0] ST_NONE = 3'd6;
  localparam logic [2:0] ST_BAD_COUNT = 3'd7;

  // register index, registers sit eight bytes apart
  localparam logic CFG_OWN_ID = 1'b0;

  // stored contact without its id
  typedef struct packed {
    logic [31:0] address;
    logic [15:0] port;
  } contact_t;
endpackage

// ----- src/xmb_sort_cell.sv -----
// one cell of the insertion sort chain: keeps one candidate, passes the larger on
// depends on xmb_pkg
module xmb_sort_cell #(
  parameter int ID_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               in_vld,
  input  logic [ID_BITS-1:0] in_key,
  input  logic [ID_BITS-1:0] in_id,
  input  xmb_pkg::contact_t  in_ct,
  input  logic               shift,
  input  logic               sh_vld,
  input  logic [ID_BITS-1:0] sh_key,
  input  logic [ID_BITS-1:0] sh_id,
  input  xmb_pkg::contact_t  sh_ct,
  output logic               out_vld,
  output logic [ID_BITS-1:0] out_key,
  output logic [ID_BITS-1:0] out_id,
  output xmb_pkg::contact_t  out_ct,
  output logic               held_vld,
  output logic [ID_BITS-1:0] held_key,
  output logic [ID_BITS-1:0] held_id,
  output xmb_pkg::contact_t  held_ct
);
  logic               vld_r;
  logic [ID_BITS-1:0] key_r, id_r;
  xmb_pkg::contact_t  ct_r;
  logic               take;

  // smaller key stays (strict, keeps gather order on ties)
  assign take = in_vld && (!vld_r || in_key < key_r);

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= 1'b0;
    end else if (shift) begin
      vld_r <= sh_vld;
    end else if (in_vld) begin
      vld_r <= 1'b1;
    end
    if (shift) begin
      key_r <= sh_key; id_r <= sh_id; ct_r <= sh_ct;
    end else if (take) begin
      key_r <= in_key; id_r <= in_id; ct_r <= in_ct;
    end
  end

  // displaced or passed-through candidate to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n || clr || shift) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld && vld_r;
    end
    out_key <= take ? key_r : in_key;
    out_id  <= take ? id_r : in_id;
    out_ct  <= take ? ct_r : in_ct;
  end

  assign held_vld = vld_r;
  assign held_key = key_r;
  assign held_id  = id_r;
  assign held_ct  = ct_r;
endmodule

// ----- src/xor_metric_bucket_table_core.sv -----
// xor-metric bucket table core: one item at a time, next item taken only once the last result is accepted
// add/remove: the result item follows the one-port slot memory scan, which reads each slot searched
// in turn and then moves slots one by one through a read and a write
// find: candidates are gathered one slot read at a time, bucket by bucket, the sort chain is drained,
// then one result item per cycle while out_tready is high; reset clears own id and fill counts
// depends on xmb_pkg, xmb_sort_cell and the macros header
`include "xor_metric_bucket_table_core_macros.svh"
module xor_metric_bucket_table_core #(
  parameter int ID_BITS = 64,
  parameter int BUCKET_SIZE = 8,
  parameter int MAX_FIND = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: command[1:0], node_id[65:2], contact_address[97:66], contact_port[113:98],
  // want_count[118:114]
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: status[2:0], found_id[66:3], found_address[98:67], found_port[114:99]
  output logic [119:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int BW = $clog2(ID_BITS);
  localparam int FW = $clog2(BUCKET_SIZE + 1);
  localparam int NSLOT = ID_BITS * BUCKET_SIZE;
  localparam int SW = $clog2(NSLOT);
  localparam int CW = $clog2(MAX_FIND + 1);
  localparam int KW = $clog2(MAX_FIND + 2);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BKT, S_SRCH, S_SRCHW, S_MOVE, S_MOVEW, S_WR, S_RESP,
    S_GNEXT, S_GFIL, S_GRD, S_GRDW, S_DRAIN, S_EMIT
  } state_t;

  // configuration
  logic [ID_BITS-1:0] own_id_r;
  logic               cfg_hit;
  assign cfg_pready = 1'b1;
  assign cfg_hit = (cfg_paddr == {xmb_pkg::CFG_OWN_ID, 3'b000});
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      own_id_r <= cfg_pwdata[ID_BITS-1:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_hit) cfg_prdata[ID_BITS-1:0] = own_id_r;
  end

  // slot memory, one port, registered read
  logic [ID_BITS-1:0] mem_id [NSLOT];
  xmb_pkg::contact_t  mem_ct [NSLOT];
  logic               mem_we;
  logic [SW-1:0]      mem_addr;
  logic [ID_BITS-1:0] mem_wid, rd_id;
  xmb_pkg::contact_t  mem_wct, rd_ct;
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_id[mem_addr] <= mem_wid;
      mem_ct[mem_addr] <= mem_wct;
    end
    rd_id <= mem_id[mem_addr];
    rd_ct <= mem_ct[mem_addr];
  end

  state_t             state_r;
  logic [1:0]         cmd_r;
  logic [ID_BITS-1:0] id_r, dist_r;
  xmb_pkg::contact_t  ct_r, hold_ct_r;
  logic [CW-1:0]      want_r, found_r;
  logic [BW-1:0]      bkt_r, t_r, cur_r, wipe_r;
  logic [FW-1:0]      n_r, p_r;
  logic               hit_r;
  logic [2:0]         status_r;
  logic [BW:0]        off_r;
  logic               side_r;
  logic [KW-1:0]      drain_r;
  logic [CW-1:0]      emit_r;
  logic               fill_we;
  logic [FW-1:0]      fill_wv;
  logic [BW-1:0]      fill_waddr;

  // priority encoder of the XOR distance
  logic [BW-1:0] msb;
  always_comb begin
    msb = '0;
    for (int b = 0; b < ID_BITS; b++) if (dist_r[b]) msb = BW'(b);
  end

  // fill counts, memory with separate read and write ports and registered read, cleared by a pass after reset
  logic [FW-1:0] fill_mem [ID_BITS];
  logic [FW-1:0] fill_rd, fill_lim;
  logic [BW-1:0] fill_raddr;
  assign fill_raddr = (state_r == S_BKT) ? msb : cur_r;
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wv;
    fill_rd <= fill_mem[fill_raddr];
  end
  assign fill_lim = (fill_rd > FW'(BUCKET_SIZE)) ? FW'(BUCKET_SIZE) : fill_rd;

  // first slot of the working bucket and of the bucket being gathered
  logic [SW-1:0] base_bkt, base_cur;
  assign base_bkt = SW'(bkt_r) * SW'(BUCKET_SIZE);
  assign base_cur = SW'(cur_r) * SW'(BUCKET_SIZE);

  // sort chain
  logic               c_in_vld [MAX_FIND+1];
  logic [ID_BITS-1:0] c_in_key [MAX_FIND+1];
  logic [ID_BITS-1:0] c_in_id  [MAX_FIND+1];
  xmb_pkg::contact_t  c_in_ct  [MAX_FIND+1];
  logic               h_vld [MAX_FIND];
  logic [ID_BITS-1:0] h_key [MAX_FIND];
  logic [ID_BITS-1:0] h_id  [MAX_FIND];
  xmb_pkg::contact_t  h_ct  [MAX_FIND];
  logic               sh, clr;
  genvar g;
  // slot read in S_GRD arrives during S_GRDW
  assign c_in_vld[0] = (state_r == S_GRDW);
  assign c_in_key[0] = rd_id ^ id_r;
  assign c_in_id[0]  = rd_id;
  assign c_in_ct[0]  = rd_ct;
  generate
    for (g = 0; g < MAX_FIND; g++) begin : g_cell
      logic               nv;
      logic [ID_BITS-1:0] nk, ni;
      xmb_pkg::contact_t  nc;
      if (g + 1 < MAX_FIND) begin : g_mid
        assign nv = h_vld[g+1]; assign nk = h_key[g+1];
        assign ni = h_id[g+1];  assign nc = h_ct[g+1];
      end else begin : g_end
        assign nv = 1'b0; assign nk = '0; assign ni = '0; assign nc = '0;
      end
      xmb_sort_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk, .rst_n, .clr,
        .in_vld(c_in_vld[g]), .in_key(c_in_key[g]), .in_id(c_in_id[g]), .in_ct(c_in_ct[g]),
        .shift(sh), .sh_vld(nv), .sh_key(nk), .sh_id(ni), .sh_ct(nc),
        .out_vld(c_in_vld[g+1]), .out_key(c_in_key[g+1]), .out_id(c_in_id[g+1]),
        .out_ct(c_in_ct[g+1]),
        .held_vld(h_vld[g]), .held_key(h_key[g]), .held_id(h_id[g]), .held_ct(h_ct[g])
      );
    end
  endgenerate

  assign in_tready = (state_r == S_IDLE);
  assign clr = (state_r == S_IDLE);
  assign sh  = (state_r == S_EMIT) && out_tready;
  assign out_tvalid = (state_r == S_RESP) || (state_r == S_EMIT);
  assign out_tlast = (state_r == S_RESP) || (emit_r + CW'(1) == found_r);
  always_comb begin
    out_tdata = '0;
    if (state_r == S_EMIT) begin
      out_tdata[2:0] = xmb_pkg::ST_ENTRY;
      out_tdata[3 +: ID_BITS] = h_id[0];
      out_tdata[98:67] = h_ct[0].address;
      out_tdata[114:99] = h_ct[0].port;
    end else begin
      out_tdata[2:0] = status_r;
    end
  end

  // memory port and fill write selection
  always_comb begin
    mem_we = 1'b0;
    mem_addr = base_bkt + SW'(p_r);
    mem_wid = id_r;
    mem_wct = ct_r;
    fill_we = 1'b0;
    fill_wv = n_r;
    fill_waddr = bkt_r;
    case (state_r)
      S_CLEAR: begin
        fill_we = 1'b1;
        fill_wv = '0;
        fill_waddr = wipe_r;
      end
      S_MOVE: begin
        // add shifts p-1 -> p, remove reads p+1
        if (cmd_r == xmb_pkg::CMD_ADD) mem_addr = base_bkt + SW'(p_r) - SW'(1);
        else mem_addr = base_bkt + SW'(p_r) + SW'(1);
      end
      S_MOVEW: begin
        mem_we = 1'b1; mem_wid = rd_id; mem_wct = rd_ct;
      end
      S_WR: begin
        if (cmd_r == xmb_pkg::CMD_ADD) begin
          mem_we = 1'b1;
          mem_addr = base_bkt;
          mem_wct = hit_r ? hold_ct_r : ct_r;
          fill_we = !hit_r;
          fill_wv = (n_r >= FW'(BUCKET_SIZE)) ? FW'(BUCKET_SIZE) : n_r + FW'(1);
        end else begin
          fill_we = hit_r;
          fill_wv = n_r - FW'(1);
        end
      end
      S_GRD: mem_addr = base_cur + SW'(p_r);
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      wipe_r <= '0;
      found_r <= '0;
      want_r <= '0;
    end else begin
      case (state_r)
        // zero every fill count once after reset
        S_CLEAR: begin
          wipe_r <= wipe_r + BW'(1);
          if (wipe_r == BW'(ID_BITS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          cmd_r  <= in_tdata[1:0];
          id_r   <= in_tdata[2 +: ID_BITS];
          dist_r <= in_tdata[2 +: ID_BITS] ^ own_id_r;
          ct_r   <= '{address: in_tdata[97:66], port: in_tdata[113:98]};
          want_r <= (int'(in_tdata[118:114]) > MAX_FIND) ? CW'(MAX_FIND)
                    : CW'(in_tdata[118:114]);
          found_r <= '0;
          emit_r <= '0;
          hit_r <= 1'b0;
          p_r <= '0;
          if (in_tdata[1:0] == xmb_pkg::CMD_FIND && in_tdata[118:114] == 5'd0) begin
            status_r <= xmb_pkg::ST_BAD_COUNT;
            state_r <= S_RESP;
          end else if (in_tdata[1:0] != xmb_pkg::CMD_SPARE) begin
            state_r <= S_BKT;
          end
        end
        S_BKT: begin
          bkt_r <= msb; t_r <= msb; cur_r <= msb;
          off_r <= '0; side_r <= 1'b0;
          state_r <= (cmd_r == xmb_pkg::CMD_FIND) ? S_GRD : S_SRCH;
        end
        S_SRCH: begin
          n_r <= fill_lim;
          if (p_r >= fill_lim) begin
            // not found
            if (cmd_r == xmb_pkg::CMD_ADD) begin
              p_r <= (fill_lim >= FW'(BUCKET_SIZE)) ? FW'(BUCKET_SIZE - 1) : fill_lim;
              status_r <= (fill_lim >= FW'(BUCKET_SIZE)) ? xmb_pkg::ST_EVICTED
                          : xmb_pkg::ST_INSERTED;
              state_r <= S_MOVE;
            end else begin
              status_r <= xmb_pkg::ST_ABSENT;
              state_r <= S_RESP;
            end
          end else begin
            state_r <= S_SRCHW;
          end
        end
        // search compare after registered read
        S_SRCHW: begin
          if (rd_id == id_r) begin
            hit_r <= 1'b1;
            hold_ct_r <= rd_ct;
            status_r <= (cmd_r == xmb_pkg::CMD_ADD) ? xmb_pkg::ST_REFRESHED
                        : xmb_pkg::ST_REMOVED;
            state_r <= S_MOVE;
          end else begin
            p_r <= p_r + FW'(1);
            state_r <= S_SRCH;
          end
        end
        S_MOVE: begin
          if (cmd_r == xmb_pkg::CMD_ADD ? (p_r == '0) : (p_r + FW'(1) >= n_r))
            state_r <= S_WR;
          else
            state_r <= S_MOVEW;
        end
        S_MOVEW: begin
          p_r <= (cmd_r == xmb_pkg::CMD_ADD) ? p_r - FW'(1) : p_r + FW'(1);
          state_r <= S_MOVE;
        end
        S_WR: state_r <= S_RESP;
        S_RESP: if (out_tready) state_r <= S_IDLE;
        // gather: read slot p of bucket cur
        S_GRD: begin
          if (found_r >= want_r) begin
            drain_r <= '0; state_r <= S_DRAIN;
          end else if (p_r < fill_lim) begin
            state_r <= S_GRDW;
          end else begin
            state_r <= S_GNEXT;
          end
        end
        S_GRDW: begin
          found_r <= found_r + CW'(1);
          p_r <= p_r + FW'(1);
          state_r <= S_GRD;
        end
        // outward bucket walk: t, t+1, t-1, t+2, t-2, ...
        S_GNEXT: begin
          p_r <= '0;
          if (!side_r) begin
            side_r <= 1'b1;
            if (off_r != '0 && off_r <= (BW+1)'(t_r)) begin
              cur_r <= t_r - BW'(off_r);
              state_r <= S_GFIL;
            end
          end else begin
            side_r <= 1'b0;
            if (off_r + (BW+1)'(1) >= (BW+1)'(ID_BITS)) begin
              drain_r <= '0; state_r <= S_DRAIN;
            end else begin
              off_r <= off_r + (BW+1)'(1);
              if ((BW+1)'(t_r) + off_r + (BW+1)'(1) < (BW+1)'(ID_BITS)) begin
                cur_r <= BW'((BW+1)'(t_r) + off_r + (BW+1)'(1));
                state_r <= S_GFIL;
              end
            end
          end
        end
        // fill count of the new bucket is read here
        S_GFIL: state_r <= S_GRD;
        // let candidates ripple to rest in the chain
        S_DRAIN: begin
          drain_r <= drain_r + KW'(1);
          if (drain_r == KW'(MAX_FIND + 1)) begin
            if (found_r == '0) begin
              status_r <= xmb_pkg::ST_NONE; state_r <= S_RESP;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: if (out_tready) begin
          emit_r <= emit_r + CW'(1);
          if (emit_r + CW'(1) == found_r) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `XMB_ASSERT(a_ready_idle, clk, rst_n, in_tready |-> !out_tvalid, "ready while result pending")
  `XMB_ASSERT(a_emit_valid, clk, rst_n, (state_r == S_EMIT) |-> h_vld[0], "emit of empty cell")
  `XMB_ASSERT(a_found_cap, clk, rst_n, found_r <= want_r, "gathered more than wanted")
endmodule
